// ----- hdl/hng_pkg.sv -----
// Shared widths, constants and pipeline payload types for the heightmap normal generator.
package hng_pkg;

   localparam int HEIGHT_BITS = 24;

   // Forward differences and their magnitudes.
   localparam int DIFF_W = HEIGHT_BITS + 1;
   localparam int MAG_W  = HEIGHT_BITS + 1;

   // Squared magnitude, and dx^2 + dy^2 + 128^2.
   localparam int SQ_W  = 2 * HEIGHT_BITS + 1;
   localparam int SUM_W = 2 * HEIGHT_BITS + 2;

   // Result magnitude k in 0..127, trial multiplier (2k + bit) one bit wider.
   localparam int K_W           = 7;
   localparam int M_W           = K_W + 1;
   localparam int SEARCH_STAGES = K_W;

   // 127^2 scale, right-hand side 127^2 * comp^2, and k^2 * S accumulator.
   localparam int SCALE_W = 14;
   localparam int RHS_W   = SQ_W + SCALE_W;
   localparam int PROD_W  = SUM_W + 2 * K_W;

   localparam int NORM_W   = 8;
   localparam int NORM_Z_W = 7;

   localparam logic [SCALE_W-1:0] SCALE_SQ = SCALE_W'(16129);
   localparam logic [SUM_W-1:0]   Z_SQ     = SUM_W'(16384);
   localparam logic [RHS_W-1:0]   RHS_Z    = RHS_W'(16129 * 16384);

   typedef struct packed {
      logic [PROD_W-1:0] p;   // k^2 * S for the bits settled so far
      logic [RHS_W-1:0]  r;   // 127^2 * comp^2
      logic [K_W-1:0]    k;
   } lane_type;

   typedef struct packed {
      logic [SUM_W-1:0] s;
      lane_type         x;
      lane_type         y;
      lane_type         z;
      logic             neg_x;
      logic             neg_y;
   } search_type;

endpackage

// ----- hdl/hng_if.sv -----
// Request and response channel interfaces for the heightmap normal generator.
interface hng_req_if;
   import hng_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [HEIGHT_BITS-1:0] h_center;
   logic signed [HEIGHT_BITS-1:0] h_right;
   logic signed [HEIGHT_BITS-1:0] h_down;

   modport source (output valid, output h_center, output h_right, output h_down,
                   input ready);
   modport sink   (input valid, input h_center, input h_right, input h_down,
                   output ready);
endinterface

interface hng_rsp_if;
   import hng_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [NORM_W-1:0]   norm_x;
   logic signed [NORM_W-1:0]   norm_y;
   logic        [NORM_Z_W-1:0] norm_z;

   modport source (output valid, output norm_x, output norm_y, output norm_z,
                   input ready);
   modport sink   (input valid, input norm_x, input norm_y, input norm_z,
                   output ready);
endinterface

// ----- hdl/hng_search.sv -----
// Bit-serial pipelined search for the three scaled normal magnitudes, one bit per stage.
module hng_search (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  hng_pkg::search_type in_item,
   output logic               out_vld,
   output hng_pkg::search_type out_item
);
   import hng_pkg::*;

   logic       vld_ff   [SEARCH_STAGES];
   search_type item_ff  [SEARCH_STAGES];
   search_type item_in  [SEARCH_STAGES];

   function automatic lane_type trial(lane_type ln, logic [SUM_W-1:0] s, int sh);
      logic [M_W-1:0]       m;
      logic [M_W+SUM_W-1:0] prod;
      logic [PROD_W-1:0]    cand;
      lane_type             res;
      // (t^2 - k^2) * S = (2k + bit) * bit * S
      m    = {ln.k, 1'b0} | (M_W'(1) << sh);
      prod = m * s;
      cand = ln.p + (PROD_W'(prod) << sh);
      res  = ln;
      if (cand <= PROD_W'(ln.r)) begin
         res.p = cand;
         res.k = ln.k | (K_W'(1) << sh);
      end
      return res;
   endfunction

   for (genvar i = 0; i < SEARCH_STAGES; i++) begin : g_stage
      localparam int BIT_POS = SEARCH_STAGES - 1 - i;
      search_type src;
      logic       src_vld;

      if (i == 0) begin : g_first
         assign src     = in_item;
         assign src_vld = in_vld;
      end else begin : g_next
         assign src     = item_ff[i-1];
         assign src_vld = vld_ff[i-1];
      end

      always_comb begin
         item_in[i]   = src;
         item_in[i].x = trial(src.x, src.s, BIT_POS);
         item_in[i].y = trial(src.y, src.s, BIT_POS);
         item_in[i].z = trial(src.z, src.s, BIT_POS);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[i] <= item_in[i];
         end
      end
   end

   assign out_vld  = vld_ff[SEARCH_STAGES-1];
   assign out_item = item_ff[SEARCH_STAGES-1];

endmodule

// ----- hdl/heightmap_normal_generator.sv -----
// Top level: terrain vertex normal from forward height differences, fully pipelined.
//
// Usage:
//   req_ch carries one vertex per request: h_center, h_right, h_down (signed).
//   rsp_ch returns norm_x, norm_y (signed bytes) and norm_z (0..127): the normal
//   along (-dx,-dy,128) scaled to length 127, each component truncated toward 0.
//   Both channels use valid/ready; a request moves when both are high.
// Path: the edge that takes a request loads the difference register; the
//   square, scale/sum, seven search stages (one result bit each) and the
//   output register follow in that order, and all of them hold while the
//   receiver stalls.
// Throughput: one request per cycle; the pipeline of eleven register stages
//   takes a new request every cycle while the output register is empty or
//   being taken.
// Stall: while rsp_ch.valid is high and rsp_ch.ready low, the whole pipeline
//   holds and req_ch.ready drops; nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits. No other state is reset.
module heightmap_normal_generator (
   input logic       clock,
   input logic       reset,
   hng_req_if.sink   req_ch,
   hng_rsp_if.source rsp_ch
);
   import hng_pkg::*;

   logic pipe_en;

   // Stage A: differences and magnitudes
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic                     a_vld_ff;
   logic [MAG_W-1:0]         a_mx_ff, a_mx_in;
   logic [MAG_W-1:0]         a_my_ff, a_my_in;
   logic                     a_neg_x_ff, a_neg_x_in;
   logic                     a_neg_y_ff, a_neg_y_in;

   // Stage B: squares
   logic                     b_vld_ff;
   logic [2*MAG_W-1:0]       prod_x, prod_y;
   logic [SQ_W-1:0]          b_sq_x_ff, b_sq_y_ff;
   logic                     b_neg_x_ff, b_neg_y_ff;

   // Stage C: S and right-hand sides
   logic                     c_vld_ff;
   logic [RHS_W-1:0]         rhs_x, rhs_y;
   search_type               c_item_ff, c_item_in;

   // Search output and response register
   logic                     srch_vld;
   search_type               srch_item;
   logic                     rsp_vld_ff;
   logic signed [NORM_W-1:0] norm_x_ff, norm_x_in;
   logic signed [NORM_W-1:0] norm_y_ff, norm_y_in;
   logic [NORM_Z_W-1:0]      norm_z_ff;

   // Everything advances together unless a finished response is held
   assign pipe_en      = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = pipe_en;

   // ---- Stage A ----
   assign dx = DIFF_W'(req_ch.h_right) - DIFF_W'(req_ch.h_center);
   assign dy = DIFF_W'(req_ch.h_down)  - DIFF_W'(req_ch.h_center);

   always_comb begin
      a_mx_in    = MAG_W'(dx[DIFF_W-1] ? -dx : dx);
      a_my_in    = MAG_W'(dy[DIFF_W-1] ? -dy : dy);
      // component is -dx: negative result when the slope rises
      a_neg_x_in = !dx[DIFF_W-1] && (dx != '0);
      a_neg_y_in = !dy[DIFF_W-1] && (dy != '0);
   end

   // ---- Stage B ----
   assign prod_x = a_mx_ff * a_mx_ff;
   assign prod_y = a_my_ff * a_my_ff;

   // ---- Stage C ----
   assign rhs_x = b_sq_x_ff * SCALE_SQ;
   assign rhs_y = b_sq_y_ff * SCALE_SQ;

   always_comb begin
      c_item_in.s     = SUM_W'(b_sq_x_ff) + SUM_W'(b_sq_y_ff) + Z_SQ;
      c_item_in.x.p   = '0;
      c_item_in.x.r   = rhs_x;
      c_item_in.x.k   = '0;
      c_item_in.y.p   = '0;
      c_item_in.y.r   = rhs_y;
      c_item_in.y.k   = '0;
      c_item_in.z.p   = '0;
      c_item_in.z.r   = RHS_Z;
      c_item_in.z.k   = '0;
      c_item_in.neg_x = b_neg_x_ff;
      c_item_in.neg_y = b_neg_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         a_vld_ff   <= req_ch.valid;
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;
         rsp_vld_ff <= srch_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_mx_ff    <= a_mx_in;
         a_my_ff    <= a_my_in;
         a_neg_x_ff <= a_neg_x_in;
         a_neg_y_ff <= a_neg_y_in;
         b_sq_x_ff  <= prod_x[SQ_W-1:0];
         b_sq_y_ff  <= prod_y[SQ_W-1:0];
         b_neg_x_ff <= a_neg_x_ff;
         b_neg_y_ff <= a_neg_y_ff;
         c_item_ff  <= c_item_in;
         norm_x_ff  <= norm_x_in;
         norm_y_ff  <= norm_y_in;
         norm_z_ff  <= srch_item.z.k;
      end
   end

   // ---- Seven-stage magnitude search ----
   hng_search u_search (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_vld   (c_vld_ff),
      .in_item  (c_item_ff),
      .out_vld  (srch_vld),
      .out_item (srch_item)
   );

   // ---- Sign restore ----
   always_comb begin
      norm_x_in = srch_item.neg_x ? (NORM_W'(0) - {1'b0, srch_item.x.k})
                                  : {1'b0, srch_item.x.k};
      norm_y_in = srch_item.neg_y ? (NORM_W'(0) - {1'b0, srch_item.y.k})
                                  : {1'b0, srch_item.y.k};
   end

   assign rsp_ch.valid  = rsp_vld_ff;
   assign rsp_ch.norm_x = norm_x_ff;
   assign rsp_ch.norm_y = norm_y_ff;
   assign rsp_ch.norm_z = norm_z_ff;

`ifndef ASSERT_OFF
   // Reset empties the front and the output of the pipeline
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_vld_ff && !a_vld_ff && !b_vld_ff && !c_vld_ff))
      else $error("valid bits not cleared by reset");

   // A held response freezes the front stages
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable({a_vld_ff, b_vld_ff, c_vld_ff}))
      else $error("pipeline moved during stall");

   // Truncated components never exceed length 127
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((int'(norm_x_ff) * int'(norm_x_ff)
                     + int'(norm_y_ff) * int'(norm_y_ff)
                     + int'(norm_z_ff) * int'(norm_z_ff)) <= 16129))
      else $error("normal longer than 127");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the heightmap normal generator: table, random vertices, stalls.
module tb_top;
   import hng_pkg::*;

   // Height range at the configured width.
   localparam int H_MAX = (1 << (HEIGHT_BITS - 1)) - 1;
   localparam int H_MIN = -(1 << (HEIGHT_BITS - 1));

   localparam int RANDOM_VERTICES = 850;
   localparam int LONG_HOLD_AT    = 300;   // requests taken before the long response hold
   localparam int LONG_HOLD_LEN   = 96;    // cycles of the long response hold
   localparam int PAUSE_AT        = 425;   // random vertex where the sender drains the pipe
   localparam int DRAIN_CYCLES    = 24;    // settle time after the last response, in cycles

   // One result, as the response channel carries it.
   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic [NORM_Z_W-1:0]      z;
   } normal_type;

   // Expected result plus the request number it belongs to, for messages.
   typedef struct packed {
      normal_type  n;
      int unsigned seq;
   } normal_entry_type;

   // Directed row: three heights, and a typed result where known is set.
   typedef struct packed {
      logic signed [HEIGHT_BITS-1:0] hc;
      logic signed [HEIGHT_BITS-1:0] hr;
      logic signed [HEIGHT_BITS-1:0] hd;
      logic                          known;
      normal_type                    want;
   } vertex_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hng_req_if req_if ();
   hng_rsp_if rsp_if ();

   heightmap_normal_generator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Scoreboard state.
   normal_entry_type expected_normals[$];
   vertex_row_type   directed_rows[$];
   int               pending        = 0;
   int unsigned      req_count      = 0;
   int unsigned      rsp_count      = 0;
   int unsigned      flat_count     = 0;
   int unsigned      vertical_count = 0;
   int unsigned      errors         = 0;

   // Typed expectation that travels with the request on the wire.
   logic             typed_known  = 1'b0;
   normal_type       typed_normal = '0;

   // Sender burst bookkeeping and receiver hold state.
   int               burst_left    = 0;
   int               rx_hold_left  = 0;
   bit               rx_hold_done  = 1'b0;
   int unsigned      rx_cycle      = 0;

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Hard ceiling on the run.
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   // Largest k in 0..127 with k*k*s <= 127^2 * cm^2, settled one bit at a
   // time from the top. 128-bit math keeps every product exact.
   function automatic logic [K_W-1:0] scaled_component(logic [127:0] s, logic [127:0] cm);
      logic [127:0] rhs;
      logic [127:0] k;
      logic [127:0] t;
      rhs = cm * cm * 128'd16129;
      k   = '0;
      for (int b = 64; b > 0; b = b / 2) begin
         t = k | 128'(b);
         if (t * t * s <= rhs) k = t;
      end
      return k[K_W-1:0];
   endfunction

   // Normal along (-dx,-dy,128) scaled to length 127, truncated toward zero.
   function automatic normal_type predict_normal(logic signed [HEIGHT_BITS-1:0] hc,
                                                 logic signed [HEIGHT_BITS-1:0] hr,
                                                 logic signed [HEIGHT_BITS-1:0] hd);
      longint            dx;
      longint            dy;
      logic [127:0]      mx;
      logic [127:0]      my;
      logic [127:0]      s;
      logic [NORM_W-1:0] ux;
      logic [NORM_W-1:0] uy;
      normal_type        n;
      dx = longint'(hr) - longint'(hc);
      dy = longint'(hd) - longint'(hc);
      mx = 128'((dx < 0) ? -dx : dx);
      my = 128'((dy < 0) ? -dy : dy);
      s  = mx * mx + my * my + 128'd16384;
      ux = NORM_W'(scaled_component(s, mx));
      uy = NORM_W'(scaled_component(s, my));
      // x and y point against the slope: a rising height gives a negative part.
      n.x = (dx > 0) ? -ux : ux;
      n.y = (dy > 0) ? -uy : uy;
      n.z = scaled_component(s, 128'd128);
      return n;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      normal_entry_type e;
      if (!reset) begin
         // Request taken: queue what it must produce.
         if (req_if.valid && req_if.ready) begin
            e.n   = typed_known ? typed_normal
                                : predict_normal(req_if.h_center, req_if.h_right,
                                                 req_if.h_down);
            e.seq = req_count;
            expected_normals.push_back(e);
            req_count++;
            pending++;
         end
         // Response taken: compare with the oldest expectation.
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_count++;
            if (rsp_if.norm_z == NORM_Z_W'(127)) flat_count++;
            if (rsp_if.norm_z == '0) vertical_count++;
            if (expected_normals.size() == 0) begin
               $error("response with no request outstanding: x=%0d y=%0d z=%0d",
                      rsp_if.norm_x, rsp_if.norm_y, rsp_if.norm_z);
               errors++;
            end else begin
               e = expected_normals.pop_front();
               pending--;
               if (rsp_if.norm_x !== e.n.x) begin
                  $error("request %0d norm_x: expected %0d, got %0d",
                         e.seq, e.n.x, rsp_if.norm_x);
                  errors++;
               end
               if (rsp_if.norm_y !== e.n.y) begin
                  $error("request %0d norm_y: expected %0d, got %0d",
                         e.seq, e.n.y, rsp_if.norm_y);
                  errors++;
               end
               if (rsp_if.norm_z !== e.n.z) begin
                  $error("request %0d norm_z: expected %0d, got %0d",
                         e.seq, e.n.z, rsp_if.norm_z);
                  errors++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: ready changes at the falling edge
   // ------------------------------------------------------------------
   // Pattern rotates through four modes: always ready, coin flip, two low in
   // every seven, mostly stalled. Once LONG_HOLD_AT requests are in, ready
   // stays low through the long hold so the pipe fills and req ready drops.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (!rx_hold_done && req_count >= LONG_HOLD_AT) begin
            rx_hold_left = LONG_HOLD_LEN;
            rx_hold_done = 1'b1;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 150) % 4)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= $urandom_range(0, 1);
               2: rsp_if.ready <= (rx_cycle % 7) >= 2;
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
   endtask

   // Offer one vertex and hold it until taken. Bursts of 1..48 requests
   // with a random idle gap between bursts; no gaps while the receiver is on its
   // long hold, so the block backs up.
   task automatic offer_vertex(logic signed [HEIGHT_BITS-1:0] hc,
                               logic signed [HEIGHT_BITS-1:0] hr,
                               logic signed [HEIGHT_BITS-1:0] hd,
                               logic known, normal_type want);
      if (burst_left == 0) begin
         if (rx_hold_left == 0) idle_cycles($urandom_range(1, 8));
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      @(negedge clock);
      req_if.valid    <= 1'b1;
      req_if.h_center <= hc;
      req_if.h_right  <= hr;
      req_if.h_down   <= hd;
      typed_known     <= known;
      typed_normal    <= want;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic add_row(int hc, int hr, int hd, logic known, int x, int y, int z);
      vertex_row_type r;
      r.hc     = HEIGHT_BITS'(hc);
      r.hr     = HEIGHT_BITS'(hr);
      r.hd     = HEIGHT_BITS'(hd);
      r.known  = known;
      r.want.x = NORM_W'(x);
      r.want.y = NORM_W'(y);
      r.want.z = NORM_Z_W'(z);
      directed_rows.push_back(r);
   endtask

   initial begin
      vertex_row_type                r;
      logic signed [HEIGHT_BITS-1:0] base;
      int                            kind;
      int                            span;

      req_if.valid    = 1'b0;
      req_if.h_center = '0;
      req_if.h_right  = '0;
      req_if.h_down   = '0;

      // Flat terrain at zero and at both ends of the range.
      add_row(0, 0, 0, 1'b1, 0, 0, 127);
      add_row(H_MAX, H_MAX, H_MAX, 1'b1, 0, 0, 127);
      add_row(H_MIN, H_MIN, H_MIN, 1'b1, 0, 0, 127);
      // Widest single-axis differences: lies almost on the axis, z gone.
      add_row(H_MIN, H_MAX, H_MIN, 1'b1, -126, 0, 0);
      add_row(H_MAX, H_MIN, H_MAX, 1'b1, 126, 0, 0);
      add_row(H_MIN, H_MIN, H_MAX, 1'b1, 0, -126, 0);
      add_row(H_MAX, H_MAX, H_MIN, 1'b1, 0, 126, 0);
      // Widest differences on both axes: 127/sqrt(2) each.
      add_row(H_MIN, H_MAX, H_MAX, 1'b1, -89, -89, 0);
      add_row(H_MAX, H_MIN, H_MIN, 1'b1, 89, 89, 0);
      // Gentle and 45-degree slopes, unit steps, sign mixes.
      add_row(0, 128, 0, 1'b0, 0, 0, 0);
      add_row(0, -128, 128, 1'b0, 0, 0, 0);
      add_row(0, 1, 0, 1'b0, 0, 0, 0);
      add_row(5, 4, 4, 1'b0, 0, 0, 0);
      add_row(-1, 0, -1, 1'b0, 0, 0, 0);
      add_row(1000, 3000, -2000, 1'b0, 0, 0, 0);
      // Steep slopes around where norm_z falls to zero.
      add_row(0, 16256, 0, 1'b0, 0, 0, 0);
      add_row(0, -16257, 0, 1'b0, 0, 0, 0);
      add_row(0, 11000, -11000, 1'b0, 0, 0, 0);
      add_row(0, 20000, 0, 1'b0, 0, 0, 0);
      // Alternating bit patterns.
      add_row(32'h555555, 32'haaaaaa, 32'h0f0f0f, 1'b0, 0, 0, 0);
      add_row(32'haaaaaa, 32'h555555, 32'hf0f0f0, 1'b0, 0, 0, 0);

      wait (!reset);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         offer_vertex(r.hc, r.hr, r.hd, r.known, r.want);
      end
      // Let the table drain before the random part.
      idle_cycles(1);
      wait (pending == 0);

      for (int i = 0; i < RANDOM_VERTICES; i++) begin
         if (i == PAUSE_AT) begin
            idle_cycles(1);
            wait (pending == 0);
         end
         kind = $urandom_range(0, 99);
         base = HEIGHT_BITS'($urandom);
         // Smooth, steep, near flat, or fully random terrain.
         if (kind < 80) begin
            span = (kind < 50) ? 300 : (kind < 70) ? 40000 : 1;
            offer_vertex(base,
                         HEIGHT_BITS'(base + ($urandom_range(0, 2 * span) - span)),
                         HEIGHT_BITS'(base + ($urandom_range(0, 2 * span) - span)),
                         1'b0, '0);
         end else begin
            offer_vertex(base, HEIGHT_BITS'($urandom), HEIGHT_BITS'($urandom), 1'b0, '0);
         end
      end

      idle_cycles(1);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d vertices, %0d normals checked (%0d flat, %0d with z at zero)",
               req_count, rsp_count, flat_count, vertical_count);
      $display("with bursty requests, patterned response stalls and one long hold");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
